// ----- rtl/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the command APDU case parser
// Payload structs of the byte channel and the result channel, and the
// decode constants.
// ----------------------------------------------------------------------------
package apc_pkg;

  localparam int unsigned FifoDepthDef = 4;

  localparam logic [16:0] MinApduLen  = 17'd4;
  localparam logic [15:0] ShortLeZero = 16'd256;
  localparam logic [15:0] MaxLe       = 16'd65535;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [16:0] total_length;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [7:0]  param_three;
    logic [15:0] command_length;
    logic [15:0] expected_length;
    logic [16:0] consumed;
    logic        le_malformed;
    logic        lc_malformed;
    logic        last;
  } out_t;

endpackage

// ----- rtl/apdu_case_parser.sv -----
// ----------------------------------------------------------------------------
// apdu_case_parser: streaming ISO 7816-4 command APDU case decoder
// A result is registered in stage A and then written to the output FIFO.
// Throughput: one byte per cycle; set by the byte capture stage. A final
// byte that is also a data byte yields two results, drained from the output
// FIFO one per cycle when not stalled; input stalls only when it lacks room.
// Reset: asynchronous, active low; clears the position counter, the stage
// valid and the FIFO; capture registers reload on the first byte of an APDU.
// ----------------------------------------------------------------------------
module apdu_case_parser #(
  parameter int unsigned FifoDepth = apc_pkg::FifoDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  apc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output apc_pkg::out_t out_data_o
);
  import apc_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  // ---------------- byte capture ----------------
  logic [16:0] pos_q, pos_d;
  logic [16:0] len_q, len_n;
  logic [31:0] hdr_q, hdr_base, hdr_n;
  logic [23:0] lenb_q, lenb_base, lenb_n;
  logic [15:0] tail_q, tail_base, tail_n;
  logic        first, in_acc, in_last, in_data_hit;
  logic [7:0]  b;
  logic [16:0] tl;
  logic [7:0]  cb4;
  logic [15:0] clc;
  logic [16:0] cstart;
  logic [16:0] pos_inc;

  assign b       = in_data_i.byte_value;
  assign tl      = in_data_i.total_length;
  assign first   = (pos_q == 17'd0);
  assign pos_inc = pos_q + 17'd1;

  always_comb begin
    len_n     = first ? ((tl < MinApduLen) ? MinApduLen : tl) : len_q;
    hdr_base  = first ? 32'd0 : hdr_q;
    lenb_base = first ? 24'd0 : lenb_q;
    tail_base = first ? 16'd0 : tail_q;
    hdr_n     = hdr_base;
    lenb_n    = lenb_base;
    if (pos_q < 17'd4) begin
      hdr_n = {hdr_base[23:0], b};
    end
    case (pos_q)
      17'd4:   lenb_n = {b, lenb_base[15:0]};
      17'd5:   lenb_n = {lenb_base[23:16], b, lenb_base[7:0]};
      17'd6:   lenb_n = {lenb_base[23:8], b};
      default: lenb_n = lenb_base;
    endcase
    tail_n = {tail_base[7:0], b};
  end

  // data byte window, using the length bytes as updated by this byte
  always_comb begin
    cb4    = lenb_n[23:16];
    clc    = (cb4 != 8'd0) ? {8'd0, cb4} : lenb_n[15:0];
    cstart = (cb4 != 8'd0) ? 17'd5 : 17'd7;
    in_data_hit = (len_n > 17'd5) && (pos_q >= 17'd5)
                  && !((cb4 == 8'd0) && (len_n == 17'd7))
                  && !({1'b0, clc} > (len_n - 17'd4))
                  && (pos_q >= cstart)
                  && (pos_q < (cstart + {1'b0, clc}));
  end

  assign in_last = (pos_inc >= len_n);
  assign pos_d   = in_last ? 17'd0 : pos_inc;

  // ---------------- stage A: snapshot of one byte ----------------
  logic        sa_valid_q, sa_data_q, sa_sum_q, sa_move;
  logic [7:0]  sa_byte_q;
  logic [31:0] sa_hdr_q;
  logic [23:0] sa_lenb_q;
  logic [15:0] sa_tail_q;
  logic [16:0] sa_len_q;
  logic [1:0]  sa_need;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign sa_need    = {1'b0, sa_data_q} + {1'b0, sa_sum_q};
  assign sa_move    = sa_valid_q &&
                      ({1'b0, cnt_q} + (CntW + 1)'(sa_need) <= (CntW + 1)'(FifoDepth));
  assign in_stall_o = sa_valid_q && !sa_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 17'd0;
      sa_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_q <= pos_d;
      end
      if (in_acc) begin
        sa_valid_q <= 1'b1;
      end else if (sa_move) begin
        sa_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q     <= len_n;
      hdr_q     <= hdr_n;
      lenb_q    <= lenb_n;
      tail_q    <= tail_n;
      sa_byte_q <= b;
      sa_data_q <= in_data_hit;
      sa_sum_q  <= in_last;
      sa_hdr_q  <= hdr_n;
      sa_lenb_q <= lenb_n;
      sa_tail_q <= tail_n;
      sa_len_q  <= len_n;
    end
  end

  // ---------------- summary decode ----------------
  out_t        sum_res, data_res;
  logic [7:0]  b4, b5, b6, t0, t1;
  logic [15:0] lc, le, lc16;
  logic [7:0]  p3;
  logic [16:0] cons, ext_end;
  logic [7:0]  k;
  logic        lef, lcf;

  always_comb begin
    b4      = sa_lenb_q[23:16];
    b5      = sa_lenb_q[15:8];
    b6      = sa_lenb_q[7:0];
    t0      = sa_tail_q[7:0];
    t1      = sa_tail_q[15:8];
    lc16    = {b5, b6};
    ext_end = 17'd7 + {1'b0, lc16};
    k       = sa_len_q[7:0] - ext_end[7:0];
    lc      = 16'd0;
    le      = 16'd0;
    p3      = 8'd0;
    cons    = sa_len_q;
    lef     = 1'b0;
    lcf     = 1'b0;
    if (sa_len_q == 17'd4) begin
      cons = 17'd4;
    end else begin
      if (sa_len_q == 17'd5) begin
        le = (b4 == 8'd0) ? ShortLeZero : {8'd0, b4};
      end else if (b4 == 8'd0) begin
        if (sa_len_q == 17'd7) begin
          le = (lc16 == 16'd0) ? MaxLe : lc16;
        end else begin
          lc = lc16;
          if (sa_len_q != ext_end) begin
            if (k == 8'd1) begin
              le = {8'd0, t0};
            end else if (k == 8'd2 || k == 8'd3) begin
              le = {t1, t0};
            end else begin
              lef = 1'b1;
            end
          end
        end
      end else begin
        lc = {8'd0, b4};
        if (sa_len_q != (17'd5 + {9'd0, b4})) begin
          le   = (t0 == 8'd0) ? MaxLe : {8'd0, t0};
          p3   = b4;
          cons = 17'd6 + {9'd0, b4};
        end
      end
      // oversized Lc is dropped and flagged
      if ({1'b0, lc} > (sa_len_q - 17'd4)) begin
        lc  = 16'd0;
        p3  = 8'd0;
        lcf = 1'b1;
      end
    end
    sum_res                 = '0;
    sum_res.cla             = sa_hdr_q[31:24];
    sum_res.ins             = sa_hdr_q[23:16];
    sum_res.param_one       = sa_hdr_q[15:8];
    sum_res.param_two       = sa_hdr_q[7:0];
    sum_res.param_three     = p3;
    sum_res.command_length  = lc;
    sum_res.expected_length = le;
    sum_res.consumed        = cons;
    sum_res.le_malformed    = lef;
    sum_res.lc_malformed    = lcf;
    sum_res.last            = 1'b1;
    data_res                = '0;
    data_res.data_byte      = sa_byte_q;
  end

  // ---------------- output FIFO ----------------
  out_t            fifo_mem [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q, wr_one;
  logic            rd_en, wr_a, wr_b;
  logic [1:0]      n_wr;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  assign out_valid_o = (cnt_q != '0);
  assign rd_en       = out_valid_o && !out_stall_i;
  assign wr_a        = sa_move && (sa_data_q || sa_sum_q);
  assign wr_b        = sa_move && sa_data_q && sa_sum_q;
  assign n_wr        = sa_move ? sa_need : 2'd0;
  assign wr_one      = ptr_inc(wr_q);
  assign cnt_d       = cnt_q + CntW'(n_wr) - CntW'(rd_en);

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      fifo_mem[wr_q] <= sa_data_q ? data_res : sum_res;
    end
    if (wr_b) begin
      fifo_mem[wr_one] <= sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_b) begin
        wr_q <= ptr_inc(wr_one);
      end else if (wr_a) begin
        wr_q <= wr_one;
      end
      if (rd_en) begin
        rd_q <= ptr_inc(rd_q);
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_data_o = fifo_mem[rd_q];

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("output FIFO count overflow");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sa_valid_q && !sa_move) |=> (sa_valid_q && $stable(sa_sum_q) && $stable(sa_data_q)))
    else $error("stalled stage lost its byte");

  a_pos_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last) |=> (pos_q == 17'd0))
    else $error("position did not restart after final byte");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(FifoDepth)) |-> (out_valid_o && !wr_a))
    else $error("full FIFO accepted a write or hid its data");

endmodule
